>>> hdl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants of the periodic timer bank: operation codes,
// field widths and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int unsigned NumTimersDef = 16;

  localparam int unsigned OpW      = 2;
  localparam int unsigned HandleW  = 4;
  localparam int unsigned TimeoutW = 32;
  localparam int unsigned MaskW    = 16;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_START  = 2'd2,
    OP_STOP   = 2'd3
  } ptb_op_e;

  typedef struct packed {
    logic exec;        // run create, start or stop from the accepted beat
    logic tick_start;  // clear the fired accumulator
    logic tick_zero;   // tick with no created timer
    logic rd_en;       // read one slot for the tick sweep
    logic rd_last;     // this read is the last slot of the sweep
  } dp_cmd_t;

endpackage

>>> hdl/periodic_timer_bank_top.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank_top
// Bank of periodic timers with create, start, stop and tick commands; a
// tick reports the expired timers as a bit mask.
//
//   channel   | handshake                | payload
//   ----------+--------------------------+-------------------------------------
//   command   | start_i, busy_o          | op_i, handle_i, timeout_i, start_now_i
//   result    | done_o (one-cycle pulse) | ok_o, handle_out_o, fired_mask_o
//
// for create, start and stop the result shows in the next cycle and busy_o
// stays low, so the next beat can follow at once. a tick reads one slot of
// the count and period memories per cycle: busy_o is high for the sweep and
// the result shows in the first cycle after it.
// reset clears the running flags and the created count; count and period
// entries are written by create before they are read.
// the receiver cannot stall: every result is a single-cycle done_o beat.
// ----------------------------------------------------------------------------
module periodic_timer_bank_top #(
  parameter int unsigned NUM_TIMERS = ptb_pkg::NumTimersDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [ptb_pkg::OpW-1:0]        op_i,
  input  logic [ptb_pkg::HandleW-1:0]    handle_i,
  input  logic [ptb_pkg::TimeoutW-1:0]   timeout_i,
  input  logic                           start_now_i,
  output logic                           done_o,
  output logic                           ok_o,
  output logic [ptb_pkg::HandleW-1:0]    handle_out_o,
  output logic [ptb_pkg::MaskW-1:0]      fired_mask_o
);
  import ptb_pkg::*;

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

  ptb_op_e       op;
  dp_cmd_t       cmd;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] created;

  assign op = ptb_op_e'(op_i);

  ptb_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .IW         (IW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .op_i      (op),
    .created_i (created),
    .busy_o    (busy_o),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  ptb_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .IW         (IW),
    .CW         (CW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rd_addr_i    (rd_addr),
    .op_i         (op),
    .handle_i     (handle_i),
    .timeout_i    (timeout_i),
    .start_now_i  (start_now_i),
    .created_o    (created),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .handle_out_o (handle_out_o),
    .fired_mask_o (fired_mask_o)
  );

endmodule

>>> hdl/ptb_ctrl.sv
// ----------------------------------------------------------------------------
// ptb_ctrl
// Controller of the periodic timer bank: accepts beats, walks the slot index
// over all created timers for a tick and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ptb_ctrl #(
  parameter int unsigned NUM_TIMERS = ptb_pkg::NumTimersDef,
  parameter int unsigned IW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
  parameter int unsigned CW         = $clog2(NUM_TIMERS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ptb_pkg::ptb_op_e  op_i,
  input  logic [CW-1:0]     created_i,
  output logic              busy_o,
  output ptb_pkg::dp_cmd_t  cmd_o,
  output logic [IW-1:0]     rd_addr_o
);
  import ptb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_WAIT
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          accept;
  logic          idx_last;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign idx_last = ((32'(idx_q) + 32'd1) == 32'(created_i));
  assign busy_o   = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_o     = '0;
    rd_addr_o = idx_q;
    case (state_q)
      ST_IDLE: begin
        rd_addr_o = '0;
        if (accept) begin
          if (op_i == OP_TICK) begin
            if (created_i == '0) begin
              cmd_o.tick_zero = 1'b1;
            end else begin
              cmd_o.tick_start = 1'b1;
              cmd_o.rd_en      = 1'b1;
              cmd_o.rd_last    = (created_i == CW'(1));
              idx_d            = IW'(1);
              state_d          = (created_i == CW'(1)) ? ST_WAIT : ST_SWEEP;
            end
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_last = idx_last;
        idx_d         = idx_q + IW'(1);
        if (idx_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

>>> hdl/ptb_dp.sv
// ----------------------------------------------------------------------------
// ptb_dp
// Datapath of the periodic timer bank: count and period memories, running
// flags, slot allocation, the one-slot-per-cycle tick pipeline and the
// result registers.
// ----------------------------------------------------------------------------
module ptb_dp #(
  parameter int unsigned NUM_TIMERS = ptb_pkg::NumTimersDef,
  parameter int unsigned IW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
  parameter int unsigned CW         = $clog2(NUM_TIMERS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ptb_pkg::dp_cmd_t               cmd_i,
  input  logic [IW-1:0]                  rd_addr_i,
  input  ptb_pkg::ptb_op_e               op_i,
  input  logic [ptb_pkg::HandleW-1:0]    handle_i,
  input  logic [ptb_pkg::TimeoutW-1:0]   timeout_i,
  input  logic                           start_now_i,
  output logic [CW-1:0]                  created_o,
  output logic                           done_o,
  output logic                           ok_o,
  output logic [ptb_pkg::HandleW-1:0]    handle_out_o,
  output logic [ptb_pkg::MaskW-1:0]      fired_mask_o
);
  import ptb_pkg::*;

  logic [TimeoutW-1:0] cnt_mem [NUM_TIMERS];
  logic [TimeoutW-1:0] per_mem [NUM_TIMERS];

  logic [NUM_TIMERS-1:0] running_q, running_d;
  logic [CW-1:0]         created_q, created_d;

  logic [TimeoutW-1:0] cnt_rd_q, per_rd_q;
  logic                rd_vld_q, rd_last_q;
  logic [IW-1:0]       rd_idx_q;

  logic [MaskW-1:0]    acc_q, acc_d;
  logic                done_q, done_d;
  logic                ok_q, ok_d;
  logic [HandleW-1:0]  hout_q, hout_d;
  logic [MaskW-1:0]    mask_q, mask_d;

  logic                cnt_we, per_we;
  logic [IW-1:0]       cnt_waddr;
  logic [TimeoutW-1:0] cnt_wdata;

  logic                have_slot, handle_ok;
  logic [IW-1:0]       new_slot, hslot;
  logic [TimeoutW-1:0] cnt_inc;
  logic                fire;
  logic [MaskW-1:0]    fire_bit;

  assign have_slot = (32'(created_q) < NUM_TIMERS);
  assign handle_ok = (32'(handle_i) < 32'(created_q));
  assign new_slot  = IW'(created_q);
  assign hslot     = IW'(handle_i);
  assign cnt_inc   = cnt_rd_q + TimeoutW'(1);
  assign fire      = (cnt_inc >= per_rd_q);
  assign fire_bit  = MaskW'(1) << rd_idx_q;

  always_comb begin
    running_d = running_q;
    created_d = created_q;
    acc_d     = acc_q;
    done_d    = 1'b0;
    ok_d      = ok_q;
    hout_d    = hout_q;
    mask_d    = mask_q;
    cnt_we    = 1'b0;
    per_we    = 1'b0;
    cnt_waddr = rd_idx_q;
    cnt_wdata = '0;

    if (cmd_i.exec) begin
      done_d = 1'b1;
      mask_d = '0;
      hout_d = '0;
      ok_d   = 1'b0;
      case (op_i)
        OP_CREATE: begin
          if (have_slot) begin
            cnt_we              = 1'b1;
            per_we              = 1'b1;
            cnt_waddr           = new_slot;
            running_d[new_slot] = start_now_i;
            created_d           = created_q + CW'(1);
            ok_d                = 1'b1;
            hout_d              = HandleW'(created_q);
          end
        end
        OP_START: begin
          if (handle_ok) begin
            cnt_we           = 1'b1;
            cnt_waddr        = hslot;
            running_d[hslot] = 1'b1;
            ok_d             = 1'b1;
          end
        end
        OP_STOP: begin
          if (handle_ok) begin
            running_d[hslot] = 1'b0;
            ok_d             = 1'b1;
          end
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end

    if (cmd_i.tick_zero) begin
      done_d = 1'b1;
      ok_d   = 1'b1;
      hout_d = '0;
      mask_d = '0;
    end

    if (cmd_i.tick_start) begin
      acc_d = '0;
    end

    if (rd_vld_q) begin
      if (running_q[rd_idx_q]) begin
        cnt_we    = 1'b1;
        cnt_waddr = rd_idx_q;
        cnt_wdata = fire ? '0 : cnt_inc;
        if (fire) begin
          acc_d = acc_q | fire_bit;
        end
      end
      if (rd_last_q) begin
        done_d = 1'b1;
        ok_d   = 1'b1;
        hout_d = '0;
        mask_d = acc_d;
      end
    end
  end

  // count and period memories
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (per_we) begin
      per_mem[new_slot] <= timeout_i;
    end
    if (cmd_i.rd_en) begin
      cnt_rd_q <= cnt_mem[rd_addr_i];
      per_rd_q <= per_mem[rd_addr_i];
      rd_idx_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      created_q <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      running_q <= running_d;
      created_q <= created_d;
      rd_vld_q  <= cmd_i.rd_en;
      rd_last_q <= cmd_i.rd_en && cmd_i.rd_last;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    ok_q   <= ok_d;
    hout_q <= hout_d;
    mask_q <= mask_d;
  end

  assign created_o    = created_q;
  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign handle_out_o = hout_q;
  assign fired_mask_o = mask_q;

endmodule
